>>> src/tspg_pkg.sv
`default_nettype none

package tspg_pkg;

    // Widths of counts and position
    localparam int STEP_W   = 16;
    localparam int POS_W    = 32;
    localparam int DELAY_W  = 14;
    localparam int SPEED_W  = 10;
    localparam int LIMIT_W  = 16;
    localparam int CFG_W    = 16;

    // Shared divider geometry
    localparam int DIVD_W   = 20;
    localparam int DIVR_W   = (STEP_W > SPEED_W) ? STEP_W : SPEED_W;
    localparam int DCNT_W   = $clog2(DIVD_W);

    // Timing constants, in ticks
    localparam logic [DELAY_W-1:0] SLOW_DELAY  = DELAY_W'(10000);
    localparam logic [DELAY_W-1:0] PULSE_TICKS = DELAY_W'(5);
    localparam logic [DELAY_W-1:0] SETUP_TICKS = DELAY_W'(5);
    localparam logic [DIVD_W-1:0]  US_PER_SEC  = DIVD_W'(1000000);

    localparam logic [SPEED_W-1:0] SPEED_MIN   = SPEED_W'(100);
    localparam logic [SPEED_W-1:0] SPEED_MAX   = SPEED_W'(1000);
    localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(400);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(50);

    // Configuration register indexes
    localparam logic CFG_MAX_SPEED   = 1'b0;
    localparam logic CFG_ACCEL_LIMIT = 1'b1;

endpackage

`default_nettype wire

>>> src/tspg_div.sv
`default_nettype none

module tspg_div
    import tspg_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DIVD_W-1:0] dividend,
    input  wire logic [DIVR_W-1:0] divisor,
    output logic                   done,
    output logic [DIVD_W-1:0]      quotient
);

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [DCNT_W-1:0] count_reg, count_next;
    logic [DIVR_W-1:0] rem_reg,   rem_next;
    logic [DIVD_W-1:0] dvd_reg,   dvd_next;
    logic [DIVR_W-1:0] dsr_reg,   dsr_next;

    logic [DIVR_W:0]   shifted;
    logic [DIVR_W:0]   diff;
    logic              fits;

    // One quotient bit a cycle, restoring form
    always_comb begin
        shifted = {rem_reg, dvd_reg[DIVD_W-1]};
        diff    = shifted - {1'b0, dsr_reg};
        fits    = (shifted >= {1'b0, dsr_reg});

        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        dsr_next   = dsr_reg;

        if (start) begin
            busy_next  = 1'b1;
            count_next = DCNT_W'(DIVD_W - 1);
            rem_next   = '0;
            dvd_next   = dividend;
            dsr_next   = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? diff[DIVR_W-1:0] : shifted[DIVR_W-1:0];
            dvd_next = {dvd_reg[DIVD_W-2:0], fits};
            if (count_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

`default_nettype wire

>>> src/trapezoid_step_pulse_generator_top.sv
`default_nettype none

// Channel   Handshake            Payload
// s_        s_valid / s_ready    s_action, s_move_steps
// m_        m_valid / m_ready    m_step_level, m_dir_level, m_driver_enable,
//                                m_moving, m_position, m_rejected
// cfg_      cfg_wen (no wait)    cfg_index, cfg_wdata
//
// A tick or a refused start gives its result in the cycle after the beat.
// An accepted start runs two divisions on the shared divider (cruise
// delay, then ramp increment) and gives its result once the second is done;
// when the ramp is empty the second is skipped and the first gives it.
// s_ready is high when no division runs and the previous result is taken or in the cycle it is.
// Synchronous active-low reset; no clearing pass.

module trapezoid_step_pulse_generator_top
    import tspg_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,

    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic             s_action,
    input  wire logic [15:0]      s_move_steps,

    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic                  m_step_level,
    output logic                  m_dir_level,
    output logic                  m_driver_enable,
    output logic                  m_moving,
    output logic signed [31:0]    m_position,
    output logic                  m_rejected,

    input  wire logic             cfg_wen,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_wdata
);

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_DIV_TGT,
        SQ_DIV_INC
    } seq_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SETUP  = 3'd1,
        PH_ACCEL  = 3'd2,
        PH_CRUISE = 3'd3,
        PH_DECEL  = 3'd4
    } phase_t;

    seq_t               seq_reg,    seq_next;
    phase_t             phase_reg,  phase_next;
    logic [SPEED_W-1:0] speed_reg,  speed_next;
    logic [LIMIT_W-1:0] limit_reg,  limit_next;
    logic [DELAY_W-1:0] tick_reg,   tick_next;
    logic [DELAY_W-1:0] cur_reg,    cur_next;
    logic [DELAY_W-1:0] inc_reg,    inc_next;
    logic [DELAY_W-1:0] tgt_reg,    tgt_next;
    logic [STEP_W-1:0]  ramp_reg,   ramp_next;
    logic [STEP_W-1:0]  cruise_reg, cruise_next;
    logic [STEP_W-1:0]  left_reg,   left_next;
    logic [STEP_W-1:0]  len_reg,    len_next;
    logic [POS_W-1:0]   pos_reg,    pos_next;
    logic               drv_reg,    drv_next;
    logic               step_reg,   step_next;
    logic               dir_reg,    dir_next;
    logic               rej_reg,    rej_next;
    logic               mval_reg,   mval_next;

    logic               div_start;
    logic [DIVD_W-1:0]  div_dividend;
    logic [DIVR_W-1:0]  div_divisor;
    logic               div_done;
    logic [DIVD_W-1:0]  div_quot;

    tspg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    logic               s_beat;
    logic [STEP_W-1:0]  len_in;
    logic [STEP_W-1:0]  quarter;
    logic [STEP_W-1:0]  ramp_in;
    logic [SPEED_W-1:0] speed_c;
    logic               do_enter;
    logic [2:0]         enter_from;
    logic [STEP_W-1:0]  left_dec;

    assign s_ready = (seq_reg == SQ_IDLE) && (!mval_reg || m_ready);
    assign s_beat  = s_valid && s_ready;

    always_comb begin
        len_in  = STEP_W'(s_move_steps);
        quarter = len_in >> 2;
        ramp_in = (32'(quarter) > 32'(limit_reg)) ? STEP_W'(limit_reg) : quarter;
        if (speed_reg < SPEED_MIN) begin
            speed_c = SPEED_MIN;
        end else if (speed_reg > SPEED_MAX) begin
            speed_c = SPEED_MAX;
        end else begin
            speed_c = speed_reg;
        end
    end

    always_comb begin
        seq_next    = seq_reg;
        phase_next  = phase_reg;
        speed_next  = speed_reg;
        limit_next  = limit_reg;
        tick_next   = tick_reg;
        cur_next    = cur_reg;
        inc_next    = inc_reg;
        tgt_next    = tgt_reg;
        ramp_next   = ramp_reg;
        cruise_next = cruise_reg;
        left_next   = left_reg;
        len_next    = len_reg;
        pos_next    = pos_reg;
        drv_next    = drv_reg;
        step_next   = step_reg;
        dir_next    = dir_reg;
        rej_next    = rej_reg;
        mval_next   = mval_reg && !m_ready;

        div_start    = 1'b0;
        div_dividend = US_PER_SEC;
        div_divisor  = DIVR_W'(speed_c);
        do_enter     = 1'b0;
        enter_from   = 3'(PH_ACCEL);
        left_dec     = left_reg - 1'b1;

        if (cfg_wen) begin
            unique case (cfg_index)
                CFG_MAX_SPEED:   speed_next = cfg_wdata[SPEED_W-1:0];
                CFG_ACCEL_LIMIT: limit_next = LIMIT_W'(cfg_wdata);
                default:         ;
            endcase
        end

        unique case (seq_reg)
            SQ_IDLE: begin
                if (s_beat) begin
                    rej_next = 1'b0;
                    if (s_action) begin
                        if (phase_reg != PH_IDLE || len_in == '0) begin
                            rej_next  = 1'b1;
                            mval_next = 1'b1;
                        end else begin
                            len_next    = len_in;
                            ramp_next   = ramp_in;
                            cruise_next = len_in - {ramp_in[STEP_W-2:0], 1'b0};
                            cur_next    = SLOW_DELAY;
                            drv_next    = 1'b1;
                            dir_next    = 1'b1;
                            step_next   = 1'b0;
                            phase_next  = PH_SETUP;
                            tick_next   = SETUP_TICKS;
                            left_next   = '0;
                            div_start   = 1'b1;
                            seq_next    = SQ_DIV_TGT;
                        end
                    end else begin
                        mval_next = 1'b1;
                        if (phase_reg != PH_IDLE) begin
                            if (tick_reg <= DELAY_W'(1)) begin
                                if (phase_reg == PH_SETUP) begin
                                    do_enter   = 1'b1;
                                    enter_from = 3'(PH_ACCEL);
                                end else if (step_reg) begin
                                    step_next = 1'b0;
                                    tick_next = (phase_reg == PH_CRUISE) ? tgt_reg : cur_reg;
                                end else begin
                                    if (phase_reg == PH_ACCEL) begin
                                        cur_next = cur_reg - inc_reg;
                                    end else if (phase_reg == PH_DECEL) begin
                                        cur_next = cur_reg + inc_reg;
                                    end
                                    left_next = left_dec;
                                    if (left_dec == '0) begin
                                        do_enter   = 1'b1;
                                        enter_from = 3'(phase_reg) + 3'd1;
                                    end else begin
                                        step_next = 1'b1;
                                        tick_next = PULSE_TICKS;
                                    end
                                end
                            end else begin
                                tick_next = tick_reg - 1'b1;
                            end
                        end
                    end
                end
            end
            SQ_DIV_TGT: begin
                if (div_done) begin
                    tgt_next = DELAY_W'(div_quot);
                    if (ramp_reg != '0) begin
                        div_start    = 1'b1;
                        div_dividend = DIVD_W'(SLOW_DELAY - DELAY_W'(div_quot));
                        div_divisor  = DIVR_W'(ramp_reg);
                        seq_next     = SQ_DIV_INC;
                    end else begin
                        inc_next  = '0;
                        mval_next = 1'b1;
                        seq_next  = SQ_IDLE;
                    end
                end
            end
            SQ_DIV_INC: begin
                if (div_done) begin
                    inc_next  = DELAY_W'(div_quot);
                    mval_next = 1'b1;
                    seq_next  = SQ_IDLE;
                end
            end
            default: seq_next = SQ_IDLE;
        endcase

        // Move to the first phase that has steps, else finish the move
        if (do_enter) begin
            if (enter_from <= 3'(PH_ACCEL) && ramp_reg != '0) begin
                phase_next = PH_ACCEL;
                left_next  = ramp_reg;
                step_next  = 1'b1;
                tick_next  = PULSE_TICKS;
            end else if (enter_from <= 3'(PH_CRUISE) && cruise_reg != '0) begin
                phase_next = PH_CRUISE;
                left_next  = cruise_reg;
                step_next  = 1'b1;
                tick_next  = PULSE_TICKS;
            end else if (enter_from <= 3'(PH_DECEL) && ramp_reg != '0) begin
                phase_next = PH_DECEL;
                left_next  = ramp_reg;
                step_next  = 1'b1;
                tick_next  = PULSE_TICKS;
            end else begin
                pos_next   = pos_reg + POS_W'(len_reg);
                phase_next = PH_IDLE;
                step_next  = 1'b0;
                drv_next   = 1'b0;
                tick_next  = '0;
                left_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg    <= SQ_IDLE;
            phase_reg  <= PH_IDLE;
            speed_reg  <= SPEED_RESET;
            limit_reg  <= LIMIT_RESET;
            tick_reg   <= '0;
            cur_reg    <= SLOW_DELAY;
            inc_reg    <= '0;
            tgt_reg    <= '0;
            ramp_reg   <= '0;
            cruise_reg <= '0;
            left_reg   <= '0;
            len_reg    <= '0;
            pos_reg    <= '0;
            drv_reg    <= 1'b0;
            step_reg   <= 1'b0;
            dir_reg    <= 1'b0;
            rej_reg    <= 1'b0;
            mval_reg   <= 1'b0;
        end else begin
            seq_reg    <= seq_next;
            phase_reg  <= phase_next;
            speed_reg  <= speed_next;
            limit_reg  <= limit_next;
            tick_reg   <= tick_next;
            cur_reg    <= cur_next;
            inc_reg    <= inc_next;
            tgt_reg    <= tgt_next;
            ramp_reg   <= ramp_next;
            cruise_reg <= cruise_next;
            left_reg   <= left_next;
            len_reg    <= len_next;
            pos_reg    <= pos_next;
            drv_reg    <= drv_next;
            step_reg   <= step_next;
            dir_reg    <= dir_next;
            rej_reg    <= rej_next;
            mval_reg   <= mval_next;
        end
    end

    // Outputs read straight from registers; the motion state only moves on a beat
    assign m_valid         = mval_reg;
    assign m_step_level    = step_reg;
    assign m_dir_level     = dir_reg;
    assign m_driver_enable = drv_reg;
    assign m_moving        = (phase_reg != PH_IDLE);
    assign m_position      = 32'($signed(pos_reg));
    assign m_rejected      = rej_reg;

endmodule

`default_nettype wire
